// File: src/pocu_pkg.sv
// pocu_pkg: shared types and constants of the pair occurrence counter
// field widths of the ports, result outcome codes, sequencer states
// no dependencies
package pocu_pkg;

  localparam int unsigned MODE_W    = 1;
  localparam int unsigned KEY_W     = 20;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned PAIR_W    = 20;
  localparam int unsigned OCC_W     = 32;
  localparam int unsigned USED_W    = 9;

  localparam logic [MODE_W-1:0] MODE_COUNT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_READ  = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_HIT    = 2'd0,
    OUTCOME_NEW    = 2'd1,
    OUTCOME_FULL   = 2'd2,
    OUTCOME_UNUSED = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_READ   = 2'd2,
    ST_RESULT = 2'd3
  } state_t;

endpackage

// File: src/pair_occurrence_counter_unit.sv
// pair_occurrence_counter_unit: counts occurrences of identifier pairs in a table
// depends on pocu_pkg and pocu_entry_ram
//
//   channel | handshake          | payload
//   in_     | in_valid/in_stall  | mode, key_first, key_second, entry_index
//   out_    | out_valid/out_stall| slot, pair_first, pair_second, occurrences,
//           |                    | outcome, entries_used
//
// a count scans the filled entries in order up to the first hit; a miss over all filled
// entries appends the pair unless the table is full: one ram read a cycle, compare in the
// cycle after its read; a read word takes one ram read, an unused index none
// the result word is valid in the cycle in_stall drops again
// reset clears the fill level and the sequencer; table contents are never read unwritten
// a word held under out_stall lets the next word run; in_stall stays high until its
// result moves into the output register
module pair_occurrence_counter_unit #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned ID_BITS    = 20,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pocu_pkg::MODE_W-1:0]  in_mode,
  input  logic [pocu_pkg::KEY_W-1:0]   in_key_first,
  input  logic [pocu_pkg::KEY_W-1:0]   in_key_second,
  input  logic [pocu_pkg::INDEX_W-1:0] in_entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pocu_pkg::SLOT_W-1:0]  out_slot,
  output logic [pocu_pkg::PAIR_W-1:0]  out_pair_first,
  output logic [pocu_pkg::PAIR_W-1:0]  out_pair_second,
  output logic [pocu_pkg::OCC_W-1:0]   out_occurrences,
  output logic [1:0]                   out_outcome,
  output logic [pocu_pkg::USED_W-1:0]  out_entries_used
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = 2 * ID_BITS + COUNT_BITS;

  // sequencer
  pocu_pkg::state_t state_r, state_nxt;

  // item registers
  logic [ID_BITS-1:0]           kf_r, kf_nxt;
  logic [ID_BITS-1:0]           ks_r, ks_nxt;
  logic [pocu_pkg::INDEX_W-1:0] idx_r, idx_nxt;

  // scan control
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] issue_r, issue_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;

  // finished result waiting for the output register
  logic [pocu_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [pocu_pkg::PAIR_W-1:0] res_first_r, res_first_nxt;
  logic [pocu_pkg::PAIR_W-1:0] res_second_r, res_second_nxt;
  logic [pocu_pkg::OCC_W-1:0]  res_occ_r, res_occ_nxt;
  pocu_pkg::outcome_t          res_outcome_r, res_outcome_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [pocu_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [pocu_pkg::PAIR_W-1:0] out_first_r, out_first_nxt;
  logic [pocu_pkg::PAIR_W-1:0] out_second_r, out_second_nxt;
  logic [pocu_pkg::OCC_W-1:0]  out_occ_r, out_occ_nxt;
  pocu_pkg::outcome_t          out_outcome_r, out_outcome_nxt;
  logic [pocu_pkg::USED_W-1:0] out_used_r, out_used_nxt;

  // table ram ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  // width adaption
  logic [63:0]           kf_in_wide, ks_in_wide;
  logic [ID_BITS-1:0]    kf_in, ks_in;
  logic [31:0]           idx_in_wide, fill_wide, rd_idx_wide;
  logic [ID_BITS-1:0]    rd_first, rd_second;
  logic [COUNT_BITS-1:0] rd_count, inc_count;
  logic [63:0]           rd_first_wide, rd_second_wide, rd_count_wide, inc_count_wide;
  logic [63:0]           kf_r_wide, ks_r_wide;
  logic [COUNT_BITS-1:0] one_count;
  logic [63:0]           one_count_wide;

  logic accept, idx_ok, hit, scan_done, table_full, out_free, issue_en;

  assign in_stall = (state_r != pocu_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign kf_in_wide  = 64'(in_key_first);
  assign ks_in_wide  = 64'(in_key_second);
  assign kf_in       = kf_in_wide[ID_BITS-1:0];
  assign ks_in       = ks_in_wide[ID_BITS-1:0];
  assign idx_in_wide = 32'(in_entry_index);
  assign fill_wide   = 32'(fill_r);
  assign rd_idx_wide = 32'(rd_idx_r);
  assign idx_ok      = idx_in_wide < fill_wide;

  assign rd_first  = rd_data[EW-1 -: ID_BITS];
  assign rd_second = rd_data[COUNT_BITS +: ID_BITS];
  assign rd_count  = rd_data[COUNT_BITS-1:0];
  // counter saturates at all ones
  assign inc_count = (&rd_count) ? rd_count : rd_count + COUNT_BITS'(1);
  assign one_count = COUNT_BITS'(1);

  assign rd_first_wide  = 64'(rd_first);
  assign rd_second_wide = 64'(rd_second);
  assign rd_count_wide  = 64'(rd_count);
  assign inc_count_wide = 64'(inc_count);
  assign one_count_wide = 64'(one_count);
  assign kf_r_wide      = 64'(kf_r);
  assign ks_r_wide      = 64'(ks_r);

  assign hit        = (state_r == pocu_pkg::ST_SCAN) && rd_pend_r
                      && (rd_first == kf_r) && (rd_second == ks_r);
  assign scan_done  = !rd_pend_r && (issue_r == fill_r);
  assign table_full = (fill_r == FW'(CAPACITY));
  assign issue_en   = (state_r == pocu_pkg::ST_SCAN) && !hit && (issue_r != fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pocu_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == pocu_pkg::MODE_COUNT) begin
            state_nxt = pocu_pkg::ST_SCAN;
          end else if (idx_ok) begin
            state_nxt = pocu_pkg::ST_READ;
          end else begin
            state_nxt = pocu_pkg::ST_RESULT;
          end
        end
      end
      pocu_pkg::ST_SCAN: begin
        if (hit || scan_done) begin
          state_nxt = pocu_pkg::ST_RESULT;
        end
      end
      pocu_pkg::ST_READ: begin
        state_nxt = pocu_pkg::ST_RESULT;
      end
      pocu_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = pocu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pocu_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    kf_nxt          = kf_r;
    ks_nxt          = ks_r;
    idx_nxt         = idx_r;
    fill_nxt        = fill_r;
    issue_nxt       = issue_r;
    rd_pend_nxt     = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    res_slot_nxt    = res_slot_r;
    res_first_nxt   = res_first_r;
    res_second_nxt  = res_second_r;
    res_occ_nxt     = res_occ_r;
    res_outcome_nxt = res_outcome_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_slot_nxt    = out_slot_r;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_occ_nxt     = out_occ_r;
    out_outcome_nxt = out_outcome_r;
    out_used_nxt    = out_used_r;
    wr_en           = 1'b0;
    wr_addr         = rd_idx_r;
    wr_data         = {rd_first, rd_second, inc_count};
    rd_en           = 1'b0;
    rd_addr         = issue_r[AW-1:0];

    unique case (state_r)
      pocu_pkg::ST_IDLE: begin
        if (accept) begin
          kf_nxt    = kf_in;
          ks_nxt    = ks_in;
          idx_nxt   = in_entry_index;
          issue_nxt = '0;
          if (in_mode == pocu_pkg::MODE_READ) begin
            if (idx_ok) begin
              rd_en   = 1'b1;
              rd_addr = idx_in_wide[AW-1:0];
            end else begin
              res_slot_nxt    = in_entry_index;
              res_first_nxt   = '0;
              res_second_nxt  = '0;
              res_occ_nxt     = '0;
              res_outcome_nxt = pocu_pkg::OUTCOME_UNUSED;
            end
          end
        end
      end
      pocu_pkg::ST_SCAN: begin
        // reads run one entry ahead of the compare
        if (issue_en) begin
          rd_en       = 1'b1;
          rd_addr     = issue_r[AW-1:0];
          rd_idx_nxt  = issue_r[AW-1:0];
          rd_pend_nxt = 1'b1;
          issue_nxt   = issue_r + FW'(1);
        end
        res_first_nxt  = kf_r_wide[pocu_pkg::PAIR_W-1:0];
        res_second_nxt = ks_r_wide[pocu_pkg::PAIR_W-1:0];
        if (hit) begin
          wr_en           = 1'b1;
          wr_addr         = rd_idx_r;
          wr_data         = {rd_first, rd_second, inc_count};
          res_slot_nxt    = rd_idx_wide[pocu_pkg::SLOT_W-1:0];
          res_occ_nxt     = inc_count_wide[pocu_pkg::OCC_W-1:0];
          res_outcome_nxt = pocu_pkg::OUTCOME_HIT;
        end else if (scan_done) begin
          if (table_full) begin
            res_slot_nxt    = '0;
            res_occ_nxt     = '0;
            res_outcome_nxt = pocu_pkg::OUTCOME_FULL;
          end else begin
            // append the pair behind the last filled entry
            wr_en           = 1'b1;
            wr_addr         = fill_r[AW-1:0];
            wr_data         = {kf_r, ks_r, one_count};
            fill_nxt        = fill_r + FW'(1);
            res_slot_nxt    = fill_wide[pocu_pkg::SLOT_W-1:0];
            res_occ_nxt     = one_count_wide[pocu_pkg::OCC_W-1:0];
            res_outcome_nxt = pocu_pkg::OUTCOME_NEW;
          end
        end
      end
      pocu_pkg::ST_READ: begin
        res_slot_nxt    = idx_r;
        res_first_nxt   = rd_first_wide[pocu_pkg::PAIR_W-1:0];
        res_second_nxt  = rd_second_wide[pocu_pkg::PAIR_W-1:0];
        res_occ_nxt     = rd_count_wide[pocu_pkg::OCC_W-1:0];
        res_outcome_nxt = pocu_pkg::OUTCOME_HIT;
      end
      pocu_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_slot_nxt    = res_slot_r;
          out_first_nxt   = res_first_r;
          out_second_nxt  = res_second_r;
          out_occ_nxt     = res_occ_r;
          out_outcome_nxt = res_outcome_r;
          out_used_nxt    = fill_wide[pocu_pkg::USED_W-1:0];
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pocu_pkg::ST_IDLE;
      fill_r      <= '0;
      issue_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kf_r          <= kf_nxt;
    ks_r          <= ks_nxt;
    idx_r         <= idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    res_slot_r    <= res_slot_nxt;
    res_first_r   <= res_first_nxt;
    res_second_r  <= res_second_nxt;
    res_occ_r     <= res_occ_nxt;
    res_outcome_r <= res_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_first_r   <= out_first_nxt;
    out_second_r  <= out_second_nxt;
    out_occ_r     <= out_occ_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_used_r    <= out_used_nxt;
  end

  pocu_entry_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AW),
    .DATA_W (EW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_slot         = out_slot_r;
  assign out_pair_first   = out_first_r;
  assign out_pair_second  = out_second_r;
  assign out_occurrences  = out_occ_r;
  assign out_outcome      = out_outcome_r;
  assign out_entries_used = out_used_r;

endmodule

// File: src/pocu_entry_ram.sv
// pocu_entry_ram: entry table of the pair occurrence counter
// one write port, one read port with registered read data
// no dependencies
module pocu_entry_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 72
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
